// ===== design/parameterized_kmp_matcher_assert.svh =====
// ----------------------------------------------------------------------------
// parameterized_kmp_matcher_assert.svh
// Assertion macros shared by the matcher checker.
// ----------------------------------------------------------------------------
`ifndef PARAMETERIZED_KMP_MATCHER_ASSERT_SVH
`define PARAMETERIZED_KMP_MATCHER_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define PKM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pkm check failed");

// Consequent must hold in the same cycle as the antecedent.
`define PKM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pkm check failed");

`endif

// ===== design/pkm_pkg.sv =====
// ----------------------------------------------------------------------------
// pkm_pkg
// Shared command codes and widths of the isomorphic KMP matcher.
// ----------------------------------------------------------------------------
package pkm_pkg;

    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int START_W = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

endpackage

// ===== design/pkm_ram.sv =====
// ----------------------------------------------------------------------------
// pkm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pkm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/parameterized_kmp_matcher.sv =====
// ----------------------------------------------------------------------------
// parameterized_kmp_matcher
// Isomorphic (parameterized) string matcher with prev-distance encoding.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_*: s_tuser is the command (clear, append pattern
//   character, text character), s_tdata the character byte. A request is
//   taken when s_tvalid and s_tready are both high.
//   Each match leaves on m_*: m_tdata is the 1-based text position where a
//   window isomorphic to the pattern starts.
// Timing:
//   One request is in work at a time. Clear, ignored, pattern-full and
//   saturated-text requests keep the block idle. Append and text read the
//   last-seen tables (S_LOOK), then compare slots, each a RAM read (S_WRD)
//   and a compare (S_WEV): one compare per failure-link step plus the final
//   one. The first append and text with an empty pattern need no compare.
//   A text match adds the failure lookup (S_FRD, S_FEV) and the output load
//   (S_EMIT). Failure walks are amortized under two steps per character.
// Reset and stall:
//   Reset (or a clear request) empties the pattern, text position and the
//   last-seen tables through per-entry valid bits, so no sweep is needed.
//   Results sit in an output register; a request can be taken while a
//   result waits. If a new match arrives while it still waits, the block
//   holds until m_tready drains it.
// ----------------------------------------------------------------------------
module parameterized_kmp_matcher #(
    parameter int unsigned MAX_PATTERN = 256,
    parameter longint unsigned MAX_TEXT = 16777215,
    parameter int unsigned ALPHABET    = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pkm_pkg::CHAR_W-1:0]    s_tdata,   // [7:0] char_value
    input  logic [pkm_pkg::CMD_W-1:0]     s_tuser,   // [1:0] command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pkm_pkg::START_W-1:0]   m_tdata    // [23:0] match_start
);

    import pkm_pkg::*;

    localparam int PW = $clog2(MAX_PATTERN + 1);              // pattern index/length
    localparam int PA = $clog2(MAX_PATTERN > 1 ? MAX_PATTERN : 2);
    localparam int FA = $clog2(MAX_PATTERN + 1);
    localparam int TW = $clog2(MAX_TEXT + 1);                 // text position
    localparam int DW = (TW > PW) ? TW : PW;                  // distance
    localparam int SW = (DW > START_W) ? DW : START_W;
    localparam int AW = $clog2(ALPHABET);

    typedef logic [AW-1:0] modtab_t [256];

    // byte to alphabet index table, built at elaboration
    function automatic modtab_t build_mod();
        modtab_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = AW'(i % ALPHABET);
        end
        return t;
    endfunction

    localparam modtab_t MOD_TAB = build_mod();

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,   // last-seen data back from RAM
        S_WRD,    // read slot j
        S_WEV,    // compare slot j, follow failure link
        S_FRD,    // read failure link of full match
        S_FEV,
        S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [AW-1:0]     chr_reg, chr_next;
    logic [PW-1:0]     plen_reg, plen_next;
    logic [PW-1:0]     fcur_reg, fcur_next;
    logic [PW-1:0]     mlen_reg, mlen_next;
    logic [TW-1:0]     tpos_reg, tpos_next;
    logic [DW-1:0]     dist_reg, dist_next;
    logic [PW-1:0]     j_reg, j_next;
    logic [START_W-1:0] start_reg, start_next;
    logic              ovld_reg, ovld_next;
    logic [START_W-1:0] odata_reg, odata_next;
    logic [ALPHABET-1:0] tvld_reg, tvld_next;
    logic [ALPHABET-1:0] pvld_reg, pvld_next;

    // RAM ports
    logic              tls_we, pls_we, pd_we, fl_we;
    logic [TW-1:0]     tls_rd;
    logic [PW-1:0]     pls_rd, pd_rd, fl_rd;
    logic [PA-1:0]     pd_waddr;
    logic [PW-1:0]     pd_wdata, pls_wdata;
    logic [FA-1:0]     fl_waddr;
    logic [PW-1:0]     fl_wdata;
    logic [AW-1:0]     in_chr;

    logic [TW-1:0]     tlast, tpos_inc;
    logic [PW-1:0]     plast, pdist;
    logic              slot_hit;
    logic [PW-1:0]     jn;
    logic [SW-1:0]     start_full;

    assign in_chr = MOD_TAB[s_tdata];

    pkm_ram #(.WIDTH(TW), .DEPTH(ALPHABET)) u_tls (
        .clk(clk), .we(tls_we), .waddr(chr_reg), .wdata(tpos_inc),
        .raddr(in_chr), .rdata(tls_rd)
    );

    pkm_ram #(.WIDTH(PW), .DEPTH(ALPHABET)) u_pls (
        .clk(clk), .we(pls_we), .waddr(chr_reg), .wdata(pls_wdata),
        .raddr(in_chr), .rdata(pls_rd)
    );

    pkm_ram #(.WIDTH(PW), .DEPTH(MAX_PATTERN)) u_pd (
        .clk(clk), .we(pd_we), .waddr(pd_waddr), .wdata(pd_wdata),
        .raddr(j_reg[PA-1:0]), .rdata(pd_rd)
    );

    pkm_ram #(.WIDTH(PW), .DEPTH(MAX_PATTERN + 1)) u_fl (
        .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
        .raddr(j_reg[FA-1:0]), .rdata(fl_rd)
    );

    // encoded distances of the incoming character
    assign tpos_inc  = tpos_reg + TW'(1);
    assign tlast     = tvld_reg[chr_reg] ? tls_rd : '0;
    assign plast     = pvld_reg[chr_reg] ? pls_rd : '0;
    assign pdist     = (plast != '0) ? (plen_reg + PW'(1) - plast) : '0;
    assign pls_wdata = plen_reg + PW'(1);
    assign pd_waddr  = plen_reg[PA-1:0];
    assign pd_wdata  = pdist;

    // slot j compare: empty slot distance accepts none or anything past j
    always_comb
    begin
        if (pd_rd == '0)
        begin
            slot_hit = (dist_reg == '0) || (dist_reg > DW'(j_reg));
        end
        else
        begin
            slot_hit = (dist_reg == DW'(pd_rd));
        end
    end

    assign jn         = slot_hit ? (j_reg + PW'(1)) : j_reg;
    assign start_full = SW'(tpos_reg) - SW'(j_reg) + SW'(1);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        chr_next   = chr_reg;
        plen_next  = plen_reg;
        fcur_next  = fcur_reg;
        mlen_next  = mlen_reg;
        tpos_next  = tpos_reg;
        dist_next  = dist_reg;
        j_next     = j_reg;
        start_next = start_reg;
        ovld_next  = ovld_reg;
        odata_next = odata_reg;
        tvld_next  = tvld_reg;
        pvld_next  = pvld_reg;
        tls_we     = 1'b0;
        pls_we     = 1'b0;
        pd_we      = 1'b0;
        fl_we      = 1'b0;
        fl_waddr   = plen_reg[FA-1:0];
        fl_wdata   = jn;

        if (ovld_reg && m_tready)
        begin
            ovld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next = cmd_t'(s_tuser);
                    chr_next = in_chr;
                    case (cmd_t'(s_tuser))
                        CMD_CLEAR:
                        begin
                            plen_next = '0;
                            fcur_next = '0;
                            mlen_next = '0;
                            tpos_next = '0;
                            tvld_next = '0;
                            pvld_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (PW'(MAX_PATTERN) > plen_reg)
                            begin
                                state_next = S_LOOK;
                            end
                        end
                        CMD_TEXT:
                        begin
                            if (TW'(MAX_TEXT) > tpos_reg)
                            begin
                                state_next = S_LOOK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_LOOK:
            begin
                if (cmd_reg == CMD_APPEND)
                begin
                    pd_we     = 1'b1;
                    pls_we    = 1'b1;
                    pvld_next[chr_reg] = 1'b1;
                    plen_next = plen_reg + PW'(1);
                    dist_next = DW'(pdist);
                    if (plen_reg == '0)
                    begin
                        fl_we      = 1'b1;
                        fl_waddr   = FA'(1);
                        fl_wdata   = '0;
                        fcur_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next     = fcur_reg;
                        state_next = S_WRD;
                    end
                end
                else
                begin
                    tls_we    = 1'b1;
                    tvld_next[chr_reg] = 1'b1;
                    tpos_next = tpos_inc;
                    dist_next = (tlast != '0) ? DW'(tpos_inc - tlast) : '0;
                    j_next    = mlen_reg;
                    state_next = (plen_reg == '0) ? S_IDLE : S_WRD;
                end
            end

            S_WRD:
            begin
                state_next = S_WEV;
            end

            S_WEV:
            begin
                if ((j_reg != '0) && !slot_hit)
                begin
                    j_next     = fl_rd;
                    state_next = S_WRD;
                end
                else if (cmd_reg == CMD_APPEND)
                begin
                    // failure link of the new length; plen already advanced
                    fl_we      = 1'b1;
                    fcur_next  = jn;
                    state_next = S_IDLE;
                end
                else if (jn >= plen_reg)
                begin
                    j_next     = jn;
                    state_next = S_FRD;
                end
                else
                begin
                    mlen_next  = jn;
                    state_next = S_IDLE;
                end
            end

            S_FRD:
            begin
                state_next = S_FEV;
            end

            S_FEV:
            begin
                mlen_next  = fl_rd;
                start_next = start_full[START_W-1:0];
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (!ovld_reg || m_tready)
                begin
                    ovld_next  = 1'b1;
                    odata_next = start_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= CMD_NONE;
            chr_reg   <= '0;
            plen_reg  <= '0;
            fcur_reg  <= '0;
            mlen_reg  <= '0;
            tpos_reg  <= '0;
            dist_reg  <= '0;
            j_reg     <= '0;
            start_reg <= '0;
            ovld_reg  <= 1'b0;
            odata_reg <= '0;
            tvld_reg  <= '0;
            pvld_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            chr_reg   <= chr_next;
            plen_reg  <= plen_next;
            fcur_reg  <= fcur_next;
            mlen_reg  <= mlen_next;
            tpos_reg  <= tpos_next;
            dist_reg  <= dist_next;
            j_reg     <= j_next;
            start_reg <= start_next;
            ovld_reg  <= ovld_next;
            odata_reg <= odata_next;
            tvld_reg  <= tvld_next;
            pvld_reg  <= pvld_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ovld_reg;
    assign m_tdata  = odata_reg;

endmodule

// ===== design/pkm_checker.sv =====
// ----------------------------------------------------------------------------
// pkm_checker
// Port-level checks of the matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "parameterized_kmp_matcher_assert.svh"

module pkm_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [pkm_pkg::CMD_W-1:0]   s_tuser,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [pkm_pkg::START_W-1:0] m_tdata
);

    import pkm_pkg::*;

    logic non_text_req;
    logic clear_req;

    assign non_text_req = s_tvalid && s_tready && (s_tuser != CMD_TEXT);
    assign clear_req    = s_tvalid && s_tready && (s_tuser == CMD_CLEAR);

    `PKM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `PKM_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
    // only text characters produce matches
    `PKM_ASSERT_NEXT(a_no_match_non_text, non_text_req, !$rose(m_tvalid))
    // clear finishes in its accept cycle
    `PKM_ASSERT_NEXT(a_clear_ready, clear_req, s_tready)
    // start positions are 1-based
    `PKM_ASSERT_NOW(a_start_nonzero, m_tvalid, m_tdata != '0)

endmodule

bind parameterized_kmp_matcher pkm_checker u_pkm_checker (.*);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the isomorphic KMP matcher: requests are sent with
// random gaps, match starts are predicted in the bench and compared in order.
// ----------------------------------------------------------------------------
module tb;
    import pkm_pkg::*;

    localparam int PAT_MAX   = 256;
    localparam int ABC       = 256;
    localparam int WDOG_MAX  = 20000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [CHAR_W-1:0]   s_tdata = '0;
    logic [CMD_W-1:0]    s_tuser = CMD_NONE;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [START_W-1:0]  m_tdata;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_cycles = 0;
    logic hold_off_go = 1'b0;
    logic hold_off_done = 1'b0;
    int errors = 0;
    int idle_cycles = 0;

    // predictor state
    int unsigned txt_last [ABC];
    int unsigned pat_last [ABC];
    int unsigned pat_dist [PAT_MAX];
    int unsigned fail_tab [PAT_MAX+1];
    int unsigned pat_len, fail_cur, match_len, txt_pos;

    logic [START_W-1:0] expected_starts [$];

    parameterized_kmp_matcher dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #4 clk = ~clk;

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic clear_model();
        for (int i = 0; i < ABC; i++)
        begin
            txt_last[i] = 0;
            pat_last[i] = 0;
        end
        for (int i = 0; i < PAT_MAX; i++) pat_dist[i] = 0;
        for (int i = 0; i <= PAT_MAX; i++) fail_tab[i] = 0;
        pat_len = 0; fail_cur = 0; match_len = 0; txt_pos = 0;
    endtask

    function automatic bit slot_ok(int unsigned gap, int unsigned slot);
        int unsigned pd;
        pd = (slot < PAT_MAX) ? pat_dist[slot] : 0;
        if (pd == 0) return gap == 0 || gap > slot;
        return gap == pd;
    endfunction

    function automatic int unsigned link_of(int unsigned k);
        return (k <= PAT_MAX) ? fail_tab[k] : 0;
    endfunction

    // advances the predictor by one request, queues any match start
    task automatic predict_match(input cmd_t cmd, input logic [7:0] ch);
        int unsigned k, pd, f, gap, j, pos;
        case (cmd)
            CMD_CLEAR: clear_model();
            CMD_APPEND:
            begin
                k = pat_len;
                if (k < PAT_MAX)
                begin
                    pd = (pat_last[ch] != 0) ? k + 1 - pat_last[ch] : 0;
                    pat_dist[k] = pd;
                    pat_last[ch] = k + 1;
                    pat_len = k + 1;
                    if (k == 0)
                    begin
                        fail_tab[1] = 0;
                        fail_cur = 0;
                    end
                    else
                    begin
                        f = fail_cur;
                        while (f > 0 && !slot_ok(pd, f)) f = link_of(f);
                        if (slot_ok(pd, f)) f++;
                        fail_tab[k+1] = f;
                        fail_cur = f;
                    end
                end
            end
            CMD_TEXT:
            begin
                if (txt_pos < 24'hFFFFFF)
                begin
                    pos = txt_pos + 1;
                    gap = (txt_last[ch] != 0) ? pos - txt_last[ch] : 0;
                    txt_last[ch] = pos;
                    txt_pos = pos;
                    if (pat_len != 0)
                    begin
                        j = match_len;
                        while (j > 0 && !slot_ok(gap, j)) j = link_of(j);
                        if (slot_ok(gap, j)) j++;
                        if (j >= pat_len)
                        begin
                            expected_starts.insert(expected_starts.size(),
                                                   START_W'(pos - j + 1));
                            match_len = link_of(j);
                        end
                        else
                            match_len = j;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // one request; valid stays high between back-to-back requests
    task automatic send_request(input cmd_t cmd, input logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= ch;
        // ready is settled at the falling edge ahead of the accepting edge
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        @(posedge clk);
        predict_match(cmd, ch);
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_starts.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic send_pattern(input logic [7:0] p [$]);
        foreach (p[i]) send_request(CMD_APPEND, p[i]);
    endtask

    // receiver: random stalls plus an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_off_go && !hold_off_done)
        begin
            hold_off_done <= 1'b1;
            hold_off_cycles <= 400;
            m_tready <= 1'b0;
        end
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_starts.size() == 0)
                report("unexpected match_start", m_tdata, 0);
            else
            begin
                if (m_tdata !== expected_starts[0])
                    report("match_start", m_tdata, expected_starts[0]);
                void'(expected_starts.pop_front());
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        logic [7:0] p [$];
        // aba-type pattern over extreme characters
        p = {8'h00, 8'hFF, 8'h00};
        send_pattern(p);
        foreach (p[i]) send_request(CMD_TEXT, p[i] ^ 8'h5A);
        send_request(CMD_TEXT, 8'hA5);
        send_request(CMD_NONE, 8'hFF);
        send_request(CMD_TEXT, 8'h0F);
        send_request(CMD_TEXT, 8'hF0);
        // pattern grown mid-text
        send_request(CMD_APPEND, 8'h77);
        send_request(CMD_TEXT, 8'h0F);
        send_request(CMD_TEXT, 8'h11);
        send_request(CMD_CLEAR, 8'h00);
        // empty pattern: text advances position but never matches
        send_request(CMD_TEXT, 8'h01);
        send_request(CMD_TEXT, 8'h01);
        send_request(CMD_APPEND, 8'h01);
        send_request(CMD_TEXT, 8'h02);
        send_request(CMD_CLEAR, 8'hFF);
        go_idle();
    endtask

    task automatic test_pattern_full();
        for (int i = 0; i < PAT_MAX + 4; i++)
            send_request(CMD_APPEND, 8'(i % 3));
        for (int i = 0; i < 40; i++)
            send_request(CMD_TEXT, 8'($urandom_range(2)));
        send_request(CMD_CLEAR, 8'h00);
        go_idle();
    endtask

    // small alphabets and short patterns give frequent matches
    task automatic test_random(input int n);
        int sent, plen, abc;
        logic [7:0] base;
        sent = 0;
        while (sent < n)
        begin
            send_request(CMD_CLEAR, 8'($urandom));
            plen = $urandom_range(1, 5);
            abc = $urandom_range(1, 3);
            base = 8'($urandom);
            for (int i = 0; i < plen; i++)
                send_request(CMD_APPEND, base + 8'($urandom_range(abc - 1)));
            for (int i = 0; i < 40; i++)
            begin
                if ($urandom_range(99) < 3)
                    send_request(cmd_t'($urandom_range(3)), 8'($urandom));
                else
                    send_request(CMD_TEXT, base + 8'($urandom_range(abc)));
            end
            sent += plen + 41;
        end
        go_idle();
    endtask

    task automatic test_backpressure();
        send_request(CMD_CLEAR, 8'h00);
        send_request(CMD_APPEND, 8'h33);
        hold_off_go <= 1'b1;
        for (int i = 0; i < 30; i++) send_request(CMD_TEXT, 8'($urandom));
        go_idle();
    endtask

    initial
    begin
        clear_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_pattern_full();
        send_idle_pct = 25; recv_idle_pct = 61;
        test_random(220);
        send_idle_pct = 61; recv_idle_pct = 25;
        test_random(220);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(220);
        test_backpressure();
        if (errors == 0 && expected_starts.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
